// ===== hw/rtl/json_token_scanner_defines.svh =====
// ---------------------------------------------------------------------------
// JSON token scanner assertion macros
// Shared helpers that clock assertions on i_clk and hold them off in reset.
// ---------------------------------------------------------------------------
`ifndef JSON_TOKEN_SCANNER_DEFINES_SVH
`define JSON_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define JTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define JTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/jts_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON token scanner package
// Token kinds, scan modes, result bundle types and small decode helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package jts_pkg;

    // Longest string is one less than the buffer size.
    localparam int STRING_BUF_BYTES = 256;
    localparam int STR_LEN_W        = $clog2(STRING_BUF_BYTES) + 1;
    localparam int MAX_RESULTS      = 3;
    localparam int VALUE_W          = 64;

    typedef enum logic [3:0] {
        K_END   = 4'd0,
        K_LBRC  = 4'd1,
        K_RBRC  = 4'd2,
        K_LBRK  = 4'd3,
        K_RBRK  = 4'd4,
        K_COLON = 4'd5,
        K_COMMA = 4'd6,
        K_STR   = 4'd7,
        K_NUM   = 4'd8,
        K_TRUE  = 4'd9,
        K_FALSE = 4'd10,
        K_NULL  = 4'd11,
        K_ERR   = 4'd12,
        K_CHAR  = 4'd13
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'd0,
        MODE_STR  = 4'd1,
        MODE_ESC  = 4'd2,
        MODE_KW   = 4'd3,
        MODE_ZERO = 4'd4,
        MODE_DEC  = 4'd5,
        MODE_HEX  = 4'd6
    } t_mode;

    typedef enum logic [1:0] {
        KW_NONE  = 2'd0,
        KW_TRUE  = 2'd1,
        KW_FALSE = 2'd2,
        KW_NULL  = 2'd3
    } t_kw_id;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
    } t_result;

    // All results caused by one byte, in order; cnt says how many are live.
    typedef struct packed {
        logic [1:0]                    cnt;
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

    // Append one result to a bundle unless it is already full.
    function automatic t_bundle f_emit(t_bundle b, t_kind kind, logic [VALUE_W-1:0] value);
        t_bundle r;
        r = b;
        if (r.cnt < 2'(MAX_RESULTS)) begin
            r.res[r.cnt].kind  = kind;
            r.res[r.cnt].value = value;
            r.cnt              = r.cnt + 2'd1;
        end
        return r;
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3..0 hold its value.
    function automatic logic [4:0] f_hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Number of bytes in each keyword.
    function automatic logic [2:0] f_kw_len(t_kw_id id);
        logic [2:0] r;
        case (id)
            KW_TRUE:  r = 3'd4;
            KW_FALSE: r = 3'd5;
            KW_NULL:  r = 3'd4;
            default:  r = 3'd1;
        endcase
        return r;
    endfunction

    // Expected keyword byte at a given position.
    function automatic logic [7:0] f_kw_char(t_kw_id id, logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (id)
            KW_TRUE: begin
                case (pos)
                    3'd0:    r = 8'h74;
                    3'd1:    r = 8'h72;
                    3'd2:    r = 8'h75;
                    3'd3:    r = 8'h65;
                    default: r = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    3'd0:    r = 8'h66;
                    3'd1:    r = 8'h61;
                    3'd2:    r = 8'h6C;
                    3'd3:    r = 8'h73;
                    3'd4:    r = 8'h65;
                    default: r = 8'h00;
                endcase
            end
            KW_NULL: begin
                case (pos)
                    3'd0:    r = 8'h6E;
                    3'd1:    r = 8'h75;
                    3'd2:    r = 8'h6C;
                    3'd3:    r = 8'h6C;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Token kind reported when a keyword completes.
    function automatic t_kind f_kw_kind(t_kw_id id);
        t_kind r;
        case (id)
            KW_TRUE:  r = K_TRUE;
            KW_FALSE: r = K_FALSE;
            KW_NULL:  r = K_NULL;
            default:  r = K_ERR;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jts_scan.sv =====
// ---------------------------------------------------------------------------
// JSON token scanner: byte scanner
// Holds the lexer state and turns one accepted byte into a result bundle.
// ---------------------------------------------------------------------------
`default_nettype none

module jts_scan
    import jts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_final_byte,
    output t_bundle         o_bundle
);

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LF_KW  = 8'h66;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam logic [STR_LEN_W-1:0] LEN_LIMIT = STR_LEN_W'(STRING_BUF_BYTES - 1);

    // What the current byte does, decoded once and shared below.
    typedef struct packed {
        logic        num;
        logic        err;
        logic        punct;
        t_kind       punct_kind;
        logic        chr;
        logic [7:0]  chr_val;
        logic        str_done;
        logic        kw_step;
        logic        kw_done;
        logic        go_esc;
        logic        go_str;
        logic        go_kw;
        t_kw_id      kw_id;
        logic        go_zero;
        logic        go_hex;
        logic        ld_digit;
        logic        mac_dec;
        logic        mac_hex;
    } t_scan_ev;

    t_mode                 r_mode,   n_mode,   s_mode;
    logic [VALUE_W-1:0]    r_acc,    n_acc,    s_acc;
    logic                  r_digit,  n_digit,  s_digit;
    logic [STR_LEN_W-1:0]  r_len,    n_len,    s_len;
    t_kw_id                r_kw_id,  n_kw_id,  s_kw_id;
    logic [2:0]            r_kw_pos, n_kw_pos, s_kw_pos;
    logic                  r_err,    n_err,    s_err;

    t_scan_ev    ev;
    logic        idle_go;
    logic        esc_ok;
    logic [7:0]  esc_chr;
    logic [4:0]  hexd;
    logic [3:0]  dig;
    t_bundle     bnd;

    assign hexd = f_hex_digit(i_text_byte);
    assign dig  = i_text_byte[3:0];

    // Byte decode for the current mode, then the between-tokens decode.
    always_comb begin
        ev      = '0;
        idle_go = 1'b0;
        esc_ok  = 1'b0;
        esc_chr = 8'h00;
        if (!r_err) begin
            case (r_mode)
                MODE_STR: begin
                    if (i_text_byte == CH_BSLASH) begin
                        ev.go_esc = 1'b1;
                    end else if (i_text_byte == CH_QUOTE) begin
                        ev.str_done = 1'b1;
                    end else begin
                        ev.chr     = 1'b1;
                        ev.chr_val = i_text_byte;
                    end
                end
                MODE_ESC: begin
                    case (i_text_byte)
                        CH_QUOTE:  begin esc_ok = 1'b1; esc_chr = CH_QUOTE;  end
                        CH_BSLASH: begin esc_ok = 1'b1; esc_chr = CH_BSLASH; end
                        CH_SLASH:  begin esc_ok = 1'b1; esc_chr = CH_SLASH;  end
                        CH_LN:     begin esc_ok = 1'b1; esc_chr = CH_LF;     end
                        CH_LR:     begin esc_ok = 1'b1; esc_chr = CH_CR;     end
                        CH_LT:     begin esc_ok = 1'b1; esc_chr = CH_TAB;    end
                        default:   begin esc_ok = 1'b0; esc_chr = 8'h00;     end
                    endcase
                    if (esc_ok) begin
                        ev.chr     = 1'b1;
                        ev.chr_val = esc_chr;
                    end else begin
                        ev.err = 1'b1;
                    end
                end
                MODE_KW: begin
                    if (r_kw_id == KW_NONE || r_kw_pos >= f_kw_len(r_kw_id) ||
                        i_text_byte != f_kw_char(r_kw_id, r_kw_pos)) begin
                        ev.err = 1'b1;
                    end else begin
                        ev.kw_step = 1'b1;
                        ev.kw_done = ((r_kw_pos + 3'd1) == f_kw_len(r_kw_id));
                    end
                end
                MODE_ZERO: begin
                    if (i_text_byte == CH_LX || i_text_byte == CH_UX) begin
                        ev.go_hex = 1'b1;
                    end else if (i_text_byte inside {[CH_0:CH_9]}) begin
                        ev.ld_digit = 1'b1;
                    end else begin
                        ev.num  = 1'b1;
                        idle_go = 1'b1;
                    end
                end
                MODE_DEC: begin
                    if (i_text_byte inside {[CH_0:CH_9]}) begin
                        ev.mac_dec = 1'b1;
                    end else begin
                        ev.num  = 1'b1;
                        idle_go = 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (hexd[4]) begin
                        ev.mac_hex = 1'b1;
                    end else if (!r_digit) begin
                        ev.err = 1'b1;
                    end else begin
                        ev.num  = 1'b1;
                        idle_go = 1'b1;
                    end
                end
                default: idle_go = 1'b1;
            endcase
        end

        // A character beyond the buffer limit turns into an error.
        if (ev.chr && r_len >= LEN_LIMIT) begin
            ev.chr = 1'b0;
            ev.err = 1'b1;
        end

        // Start of the next token.
        if (idle_go) begin
            case (i_text_byte)
                CH_SP, CH_TAB, CH_LF, CH_CR: begin
                    ev.punct = 1'b0;
                end
                CH_LBRC:  begin ev.punct = 1'b1; ev.punct_kind = K_LBRC;  end
                CH_RBRC:  begin ev.punct = 1'b1; ev.punct_kind = K_RBRC;  end
                CH_LBRK:  begin ev.punct = 1'b1; ev.punct_kind = K_LBRK;  end
                CH_RBRK:  begin ev.punct = 1'b1; ev.punct_kind = K_RBRK;  end
                CH_COLON: begin ev.punct = 1'b1; ev.punct_kind = K_COLON; end
                CH_COMMA: begin ev.punct = 1'b1; ev.punct_kind = K_COMMA; end
                CH_QUOTE: ev.go_str = 1'b1;
                CH_LT:    begin ev.go_kw = 1'b1; ev.kw_id = KW_TRUE;  end
                CH_LF_KW: begin ev.go_kw = 1'b1; ev.kw_id = KW_FALSE; end
                CH_LN:    begin ev.go_kw = 1'b1; ev.kw_id = KW_NULL;  end
                CH_0:     ev.go_zero = 1'b1;
                default: begin
                    if (i_text_byte inside {[CH_1:CH_9]}) begin
                        ev.ld_digit = 1'b1;
                    end else begin
                        ev.err = 1'b1;
                    end
                end
            endcase
        end
    end

    // Next state: state after the byte scan, then the end-of-text clear.
    always_comb begin
        s_err = r_err | ev.err;

        if (ev.err) begin
            s_mode = MODE_IDLE;
        end else if (ev.go_esc) begin
            s_mode = MODE_ESC;
        end else if (ev.chr) begin
            s_mode = MODE_STR;
        end else if (ev.kw_step && !ev.kw_done) begin
            s_mode = MODE_KW;
        end else if (ev.go_hex || ev.mac_hex) begin
            s_mode = MODE_HEX;
        end else if (ev.ld_digit || ev.mac_dec) begin
            s_mode = MODE_DEC;
        end else if (ev.go_str) begin
            s_mode = MODE_STR;
        end else if (ev.go_kw) begin
            s_mode = MODE_KW;
        end else if (ev.go_zero) begin
            s_mode = MODE_ZERO;
        end else begin
            s_mode = MODE_IDLE;
        end

        if (ev.go_hex || ev.go_zero) begin
            s_acc = '0;
        end else if (ev.ld_digit) begin
            s_acc = VALUE_W'(dig);
        end else if (ev.mac_dec) begin
            s_acc = (r_acc << 3) + (r_acc << 1) + VALUE_W'(dig);
        end else if (ev.mac_hex) begin
            s_acc = {r_acc[VALUE_W-5:0], hexd[3:0]};
        end else begin
            s_acc = r_acc;
        end

        if (ev.go_hex || ev.num) begin
            s_digit = 1'b0;
        end else if (ev.mac_hex) begin
            s_digit = 1'b1;
        end else begin
            s_digit = r_digit;
        end

        if (ev.go_str) begin
            s_len = '0;
        end else if (ev.chr) begin
            s_len = r_len + STR_LEN_W'(1);
        end else begin
            s_len = r_len;
        end

        if (ev.go_kw) begin
            s_kw_id  = ev.kw_id;
            s_kw_pos = 3'd1;
        end else if (ev.kw_done) begin
            s_kw_id  = KW_NONE;
            s_kw_pos = 3'd0;
        end else if (ev.kw_step) begin
            s_kw_id  = r_kw_id;
            s_kw_pos = r_kw_pos + 3'd1;
        end else begin
            s_kw_id  = r_kw_id;
            s_kw_pos = r_kw_pos;
        end

        if (i_final_byte) begin
            n_mode   = MODE_IDLE;
            n_acc    = '0;
            n_digit  = 1'b0;
            n_len    = '0;
            n_kw_id  = KW_NONE;
            n_kw_pos = 3'd0;
            n_err    = 1'b0;
        end else begin
            n_mode   = s_mode;
            n_acc    = s_acc;
            n_digit  = s_digit;
            n_len    = s_len;
            n_kw_id  = s_kw_id;
            n_kw_pos = s_kw_pos;
            n_err    = s_err;
        end
    end

    // Outputs: results of the byte scan, the end-of-text flush and end.
    always_comb begin
        bnd = '0;
        if (ev.num) begin
            bnd = f_emit(bnd, K_NUM, r_acc);
        end
        if (ev.punct) begin
            bnd = f_emit(bnd, ev.punct_kind, '0);
        end
        if (ev.err) begin
            bnd = f_emit(bnd, K_ERR, '0);
        end
        if (ev.chr) begin
            bnd = f_emit(bnd, K_CHAR, VALUE_W'(ev.chr_val));
        end
        if (ev.str_done) begin
            bnd = f_emit(bnd, K_STR, VALUE_W'(r_len));
        end
        if (ev.kw_done) begin
            bnd = f_emit(bnd, f_kw_kind(r_kw_id), '0);
        end
        if (i_final_byte) begin
            if (!s_err) begin
                case (s_mode)
                    MODE_ZERO, MODE_DEC: bnd = f_emit(bnd, K_NUM, s_acc);
                    MODE_HEX: begin
                        if (s_digit) begin
                            bnd = f_emit(bnd, K_NUM, s_acc);
                        end else begin
                            bnd = f_emit(bnd, K_ERR, '0);
                        end
                    end
                    MODE_STR, MODE_ESC, MODE_KW: bnd = f_emit(bnd, K_ERR, '0);
                    default: bnd = bnd;
                endcase
            end
            bnd = f_emit(bnd, K_END, '0);
        end
    end

    assign o_bundle = bnd;

    // Lexer state registers, updated once per accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_acc    <= '0;
            r_digit  <= 1'b0;
            r_len    <= '0;
            r_kw_id  <= KW_NONE;
            r_kw_pos <= 3'd0;
            r_err    <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_digit  <= n_digit;
            r_len    <= n_len;
            r_kw_id  <= n_kw_id;
            r_kw_pos <= n_kw_pos;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jts_outq.sv =====
// ---------------------------------------------------------------------------
// JSON token scanner: result queue
// Two-bundle queue that hands results out one item per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module jts_outq
    import jts_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_bundle       i_bundle,
    input  wire logic          i_stall,
    output logic               o_full,
    output logic               o_valid,
    output t_kind              o_kind,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_last
);

    t_bundle     r_slot [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_count, n_count;
    logic [1:0]  r_idx,   n_idx;

    t_bundle     head;
    t_result     cur;
    logic        pop_res;
    logic        pop_bnd;

    // Head bundle and the result currently offered.
    assign head    = r_slot[r_rd];
    assign cur     = head.res[r_idx];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_kind  = cur.kind;
    assign o_value = cur.value;
    assign o_last  = (r_idx == (head.cnt - 2'd1));

    assign pop_res = o_valid && !i_stall;
    assign pop_bnd = pop_res && o_last;

    // Occupancy and position within the head bundle.
    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, pop_bnd};
        if (pop_bnd) begin
            n_idx = 2'd0;
        end else if (pop_res) begin
            n_idx = r_idx + 2'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
            r_idx   <= 2'd0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop_bnd) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Bundle storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_bundle;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/json_token_scanner.sv =====
// ---------------------------------------------------------------------------
// JSON token scanner
// Takes one byte of JSON text per accepted item and emits its tokens: the
// six punctuation marks, true, false, null, decimal and 0x hex numbers
// (64 bits, wrapping), string characters followed by the string token with
// its length, errors, and end after the byte flagged as final. The scanner
// accepts one byte every cycle unless stalled; each byte is fully scanned in
// the cycle it is accepted and yields zero to three results, which go into a
// two-bundle result queue that delivers one result per cycle unless the
// receiver stalls. Input stalls only when both queue slots hold results, so
// the sustained rate is one byte per cycle whenever bytes average at most one
// result each, and otherwise is set by the output at one result per cycle.
// With the queue empty, a byte's first result is offered the next cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "json_token_scanner_defines.svh"

module json_token_scanner
    import jts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_text_byte,
    input  wire logic               i_final_byte,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_token_kind,
    output logic [VALUE_W-1:0]      o_token_value,
    output logic                    o_run_last
);

    logic     take;
    logic     push;
    logic     q_full;
    t_bundle  bundle;
    t_kind    kind;

    // Input handshake: a byte is taken whenever the queue has a free slot.
    assign take    = i_valid && !o_stall;
    assign push    = take && (bundle.cnt != 2'd0);
    assign o_stall = q_full;

    jts_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_bundle     (bundle)
    );

    jts_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_stall  (i_stall),
        .o_full   (q_full),
        .o_valid  (o_valid),
        .o_kind   (kind),
        .o_value  (o_token_value),
        .o_last   (o_run_last)
    );

    assign o_token_kind = kind;

    // A full queue always has a result on offer.
    `JTS_ASSERT_NOW(a_full_has_output, o_stall, o_valid, "queue full with no output")

    // The final byte always produces at least the end item.
    `JTS_ASSERT_NEXT(a_final_gives_output, i_valid && !o_stall && i_final_byte, o_valid,
                     "final byte produced no item")

    // End is always the last result of its byte.
    `JTS_ASSERT_NOW(a_end_is_last, o_valid && o_token_kind == K_END, o_run_last,
                    "end item not marked last")

    // String characters stay within the byte range.
    `JTS_ASSERT_NOW(a_char_range, o_valid && o_token_kind == K_CHAR,
                    o_token_value[VALUE_W-1:8] == '0, "string char out of range")

endmodule

`default_nettype wire

// ===== dv/jts_token_checker.sv =====
// ---------------------------------------------------------------------------
// JSON token scanner checker
// Watches the byte and token channels of the scanner. Every accepted byte
// is run through a cycle-free model of the lexer, and the tokens it causes
// are queued in order. Every accepted token is compared field by field with
// the oldest queued one. Counters go back to the testbench top.
// ---------------------------------------------------------------------------
module jts_token_checker
    import jts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    input  logic               i_byte_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_final_byte,
    input  logic               i_token_valid,
    input  logic               i_token_stall,
    input  logic [3:0]         i_token_kind,
    input  logic [VALUE_W-1:0] i_token_value,
    input  logic               i_run_last,
    output int                 o_mismatch_count,
    output int                 o_tokens_waiting,
    output int                 o_tokens_checked,
    output logic [13:0]        o_kinds_seen
);

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_token;

    // Tokens still owed by the scanner, oldest first.
    t_token expected_tokens[$];
    t_token head_token;

    // Tokens caused by the byte being scanned.
    t_token byte_tokens[MAX_RESULTS];
    int     n_byte_tokens;

    // Lexer state.
    t_mode              mode;
    logic [VALUE_W-1:0] num_acc;
    logic               hex_digit_seen;
    logic [8:0]         str_len;
    t_kw_id             kw_sel;
    logic [2:0]         kw_pos;
    logic               err_held;

    task automatic clear_lexer();
        mode           = MODE_IDLE;
        num_acc        = '0;
        hex_digit_seen = 1'b0;
        str_len        = '0;
        kw_sel         = KW_NONE;
        kw_pos         = '0;
        err_held       = 1'b0;
    endtask

    // At most three tokens come from one byte; further ones are dropped.
    task automatic push_token(t_kind kind, logic [VALUE_W-1:0] value);
        if (n_byte_tokens < MAX_RESULTS) begin
            byte_tokens[n_byte_tokens] = '{kind: kind, value: value, last: 1'b0};
            n_byte_tokens++;
        end
    endtask

    task automatic flag_error();
        push_token(K_ERR, '0);
        err_held = 1'b1;
        mode     = MODE_IDLE;
    endtask

    // One decoded character; the buffer holds one less than its size.
    task automatic add_string_char(logic [7:0] ch);
        if (str_len >= 9'(STRING_BUF_BYTES - 1)) begin
            flag_error();
        end else begin
            push_token(K_CHAR, VALUE_W'(ch));
            str_len = str_len + 9'd1;
        end
    endtask

    // A byte seen between tokens.
    task automatic start_token(logic [7:0] c);
        mode = MODE_IDLE;
        case (c)
            " ", "\t", "\n", "\r": ;
            "{": push_token(K_LBRC, '0);
            "}": push_token(K_RBRC, '0);
            "[": push_token(K_LBRK, '0);
            "]": push_token(K_RBRK, '0);
            ":": push_token(K_COLON, '0);
            ",": push_token(K_COMMA, '0);
            "\"": begin
                mode    = MODE_STR;
                str_len = '0;
            end
            "t", "f", "n": begin
                mode   = MODE_KW;
                kw_sel = (c == "t") ? KW_TRUE : ((c == "f") ? KW_FALSE : KW_NULL);
                kw_pos = 3'd1;
            end
            default: begin
                if (c == "0") begin
                    mode    = MODE_ZERO;
                    num_acc = '0;
                end else if (c >= "1" && c <= "9") begin
                    mode    = MODE_DEC;
                    num_acc = VALUE_W'(c - "0");
                end else begin
                    flag_error();
                end
            end
        endcase
    endtask

    // Scan one accepted byte and queue the tokens it causes.
    task automatic scan_text_byte(logic [7:0] c, logic fin);
        string word;
        int    h;
        logic  esc_ok;
        logic [7:0] decoded;
        n_byte_tokens = 0;
        if (!err_held) begin
            case (mode)
                MODE_STR: begin
                    if (c == "\\") begin
                        mode = MODE_ESC;
                    end else if (c == "\"") begin
                        push_token(K_STR, VALUE_W'(str_len));
                        mode = MODE_IDLE;
                    end else begin
                        add_string_char(c);
                    end
                end
                MODE_ESC: begin
                    esc_ok  = 1'b1;
                    decoded = c;
                    case (c)
                        "\"", "\\", "/": ;
                        "n": decoded = 8'h0A;
                        "r": decoded = 8'h0D;
                        "t": decoded = 8'h09;
                        default: esc_ok = 1'b0;
                    endcase
                    if (!esc_ok) begin
                        flag_error();
                    end else begin
                        mode = MODE_STR;
                        add_string_char(decoded);
                    end
                end
                MODE_KW: begin
                    case (kw_sel)
                        KW_TRUE:  word = "true";
                        KW_FALSE: word = "false";
                        KW_NULL:  word = "null";
                        default:  word = "";
                    endcase
                    if (int'(kw_pos) >= word.len() || c != word[kw_pos]) begin
                        flag_error();
                    end else begin
                        kw_pos = kw_pos + 3'd1;
                        if (int'(kw_pos) == word.len()) begin
                            case (kw_sel)
                                KW_TRUE:  push_token(K_TRUE, '0);
                                KW_FALSE: push_token(K_FALSE, '0);
                                default:  push_token(K_NULL, '0);
                            endcase
                            mode   = MODE_IDLE;
                            kw_sel = KW_NONE;
                            kw_pos = '0;
                        end
                    end
                end
                MODE_ZERO: begin
                    if (c == "x" || c == "X") begin
                        mode           = MODE_HEX;
                        num_acc        = '0;
                        hex_digit_seen = 1'b0;
                    end else if (c >= "0" && c <= "9") begin
                        mode    = MODE_DEC;
                        num_acc = VALUE_W'(c - "0");
                    end else begin
                        push_token(K_NUM, '0);
                        start_token(c);
                    end
                end
                MODE_DEC: begin
                    if (c >= "0" && c <= "9") begin
                        num_acc = num_acc * VALUE_W'(10) + VALUE_W'(c - "0");
                    end else begin
                        push_token(K_NUM, num_acc);
                        start_token(c);
                    end
                end
                MODE_HEX: begin
                    if (c >= "0" && c <= "9") begin
                        h = c - "0";
                    end else if (c >= "a" && c <= "f") begin
                        h = c - "a" + 10;
                    end else if (c >= "A" && c <= "F") begin
                        h = c - "A" + 10;
                    end else begin
                        h = -1;
                    end
                    if (h >= 0) begin
                        num_acc        = {num_acc[VALUE_W-5:0], 4'(h)};
                        hex_digit_seen = 1'b1;
                    end else if (!hex_digit_seen) begin
                        flag_error();
                    end else begin
                        push_token(K_NUM, num_acc);
                        hex_digit_seen = 1'b0;
                        start_token(c);
                    end
                end
                default: start_token(c);
            endcase
        end

        // The final byte flushes a pending number and closes the text.
        if (fin) begin
            if (!err_held) begin
                case (mode)
                    MODE_ZERO, MODE_DEC: push_token(K_NUM, num_acc);
                    MODE_HEX: begin
                        if (hex_digit_seen) begin
                            push_token(K_NUM, num_acc);
                        end else begin
                            push_token(K_ERR, '0);
                        end
                    end
                    MODE_STR, MODE_ESC, MODE_KW: push_token(K_ERR, '0);
                    default: ;
                endcase
            end
            push_token(K_END, '0);
            clear_lexer();
        end

        if (n_byte_tokens > 0) begin
            byte_tokens[n_byte_tokens-1].last = 1'b1;
        end
        for (int i = 0; i < n_byte_tokens; i++) begin
            expected_tokens.push_back(byte_tokens[i]);
        end
    endtask

    // Compare tokens first, then predict from the byte taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lexer();
            expected_tokens.delete();
            o_mismatch_count = 0;
            o_tokens_checked = 0;
            o_kinds_seen     = '0;
        end else begin
            if (i_token_valid && !i_token_stall) begin
                o_tokens_checked++;
                if (i_token_kind < 4'd14) begin
                    o_kinds_seen[i_token_kind] = 1'b1;
                end
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: kind %0d value 0x%0h",
                           i_token_kind, i_token_value);
                    o_mismatch_count++;
                end else begin
                    head_token = expected_tokens.pop_front();
                    if (i_token_kind !== head_token.kind) begin
                        $error("token_kind mismatch: expected %0d, got %0d",
                               head_token.kind, i_token_kind);
                        o_mismatch_count++;
                    end
                    if (i_token_value !== head_token.value) begin
                        $error("token_value mismatch: expected 0x%0h, got 0x%0h",
                               head_token.value, i_token_value);
                        o_mismatch_count++;
                    end
                    if (i_run_last !== head_token.last) begin
                        $error("run_last mismatch: expected %0b, got %0b",
                               head_token.last, i_run_last);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_byte_valid && !i_byte_stall) begin
                scan_text_byte(i_text_byte, i_final_byte);
            end
        end
        o_tokens_waiting = expected_tokens.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// JSON token scanner testbench
// Feeds the scanner short directed texts and then random JSON-like texts
// built from token generators (punctuation, keywords, numbers, strings with
// escapes, stray bytes and deliberate faults), under three pacing phases of
// sender and receiver idling. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
    import jts_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 45;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_text_byte;
    logic               i_final_byte;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [3:0]         o_token_kind;
    logic [VALUE_W-1:0] o_token_value;
    logic               o_run_last;

    int          mismatch_count;
    int          tokens_waiting;
    int          tokens_checked;
    logic [13:0] kinds_seen;

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int texts_sent;
    int quiet_cycles;

    // Bytes of the text being assembled.
    logic [7:0] text_buf[$];

    always #4 i_clk = ~i_clk;

    json_token_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_final_byte  (i_final_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_run_last    (o_run_last)
    );

    jts_token_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte_valid     (i_valid),
        .i_byte_stall     (o_stall),
        .i_text_byte      (i_text_byte),
        .i_final_byte     (i_final_byte),
        .i_token_valid    (o_valid),
        .i_token_stall    (i_stall),
        .i_token_kind     (o_token_kind),
        .i_token_value    (o_token_value),
        .i_run_last       (o_run_last),
        .o_mismatch_count (mismatch_count),
        .o_tokens_waiting (tokens_waiting),
        .o_tokens_checked (tokens_checked),
        .o_kinds_seen     (kinds_seen)
    );

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, with random idle cycles ahead of it, until it is taken.
    task automatic send_byte(logic [7:0] c, logic fin);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_text_byte  <= c;
        i_final_byte <= fin;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        bytes_sent++;
    endtask

    // Send the assembled text with the final flag on its last byte.
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
        texts_sent++;
    endtask

    // Hold the sender off until every owed token has come out.
    task automatic drain_tokens();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (tokens_waiting != 0);
        @(posedge i_clk);
    endtask

    task automatic append_chars(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endtask

    // A string of n decoded characters: printable, control and high bytes,
    // escapes, and optionally a bad escape.
    task automatic append_string(int n_chars, logic close_it, logic allow_bad_escape);
        string      esc_set;
        int         r;
        logic [7:0] c;
        esc_set = "\"\\/nrt";
        text_buf.push_back("\"");
        repeat (n_chars) begin
            r = $urandom_range(99);
            if (r < 65) begin
                c = 8'($urandom_range(126, 32));
                if (c == "\"" || c == "\\") begin
                    c = "a";
                end
                text_buf.push_back(c);
            end else if (r < 75) begin
                text_buf.push_back(8'($urandom_range(31, 0)));
            end else if (r < 82) begin
                text_buf.push_back(8'($urandom_range(255, 128)));
            end else if (r < 98 || !allow_bad_escape) begin
                text_buf.push_back("\\");
                text_buf.push_back(esc_set[$urandom_range(5)]);
            end else begin
                c = 8'($urandom_range(255));
                if (c == "\"" || c == "\\" || c == "/" || c == "n" || c == "r" || c == "t") begin
                    c = "q";
                end
                text_buf.push_back("\\");
                text_buf.push_back(c);
            end
        end
        if (close_it) begin
            text_buf.push_back("\"");
        end
    endtask

    // Mostly well-formed token sequences with random content, plus faults.
    task automatic build_random_text();
        string punct;
        string hex_chars;
        string ws;
        string word;
        int    pick;
        int    n;
        int    pos;
        punct     = "{}[]:,";
        hex_chars = "0123456789abcdefABCDEF";
        ws        = " \t\n\r";
        repeat ($urandom_range(8, 1)) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                text_buf.push_back(punct[$urandom_range(5)]);
            end else if (pick < 38) begin
                case ($urandom_range(2))
                    0:       word = "true";
                    1:       word = "false";
                    default: word = "null";
                endcase
                n = word.len();
                pos = $urandom_range(n - 1, 1);
                case ($urandom_range(9))
                    0: begin
                        // Truncated keyword.
                        for (int i = 0; i < pos; i++) begin
                            text_buf.push_back(word[i]);
                        end
                    end
                    1: begin
                        // One byte replaced somewhere after the first.
                        append_chars(word);
                        text_buf[text_buf.size() - n + pos] = 8'($urandom_range(255));
                    end
                    default: append_chars(word);
                endcase
            end else if (pick < 56) begin
                // Decimal, sometimes with leading zeros or past 64 bits.
                n = ($urandom_range(4) == 0) ? $urandom_range(22, 18) : $urandom_range(6, 1);
                text_buf.push_back($urandom_range(9) == 0 ? "0" : 8'($urandom_range(57, 48)));
                repeat (n - 1) begin
                    text_buf.push_back(8'($urandom_range(57, 48)));
                end
            end else if (pick < 68) begin
                // Hex with either prefix; no digits at all now and then.
                text_buf.push_back("0");
                text_buf.push_back($urandom_range(1) ? "x" : "X");
                n = ($urandom_range(9) == 0) ? 0 : $urandom_range(18, 1);
                repeat (n) begin
                    text_buf.push_back(hex_chars[$urandom_range(21)]);
                end
            end else if (pick < 94) begin
                append_string($urandom_range(12), $urandom_range(19) != 0, 1'b1);
            end else begin
                text_buf.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(3) == 0) begin
                text_buf.push_back(ws[$urandom_range(3)]);
            end
        end
    endtask

    initial begin
        int phase_start;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_text_byte   = '0;
        i_final_byte  = 1'b0;
        bytes_sent    = 0;
        texts_sent    = 0;
        send_idle_pct = 21;
        recv_idle_pct = 86;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: escapes and null in an object, leading zeros and hex in
        // an array, an empty hex number closed by the final byte, a stray byte.
        append_chars("{\"\\/\":null}");
        send_text();
        append_chars("[007,0XfF]");
        send_text();
        append_chars("0x");
        send_text();
        text_buf.push_back(8'hFF);
        send_text();
        drain_tokens();

        // Random texts under three pacing phases.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_random_text();
                send_text();
            end
            drain_tokens();
        end

        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        $display("Scanned %0d texts (%0d bytes) under three sender/receiver pacing phases.",
                 texts_sent, bytes_sent);
        $display("Checked %0d tokens covering %0d of 14 token kinds.",
                 tokens_checked, $countones(kinds_seen));
        if (mismatch_count == 0 && tokens_waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
